@@ hw/rtl/array_tree_postorder_walk_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the tree walk block
// Shorthand for clocked implication checks with a disable-on-reset guard.
// ----------------------------------------------------------------------------
`ifndef ARRAY_TREE_POSTORDER_WALK_ASSERT_SVH
`define ARRAY_TREE_POSTORDER_WALK_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ATPW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ATPW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/atpw_pkg.sv @@
// ----------------------------------------------------------------------------
// atpw_pkg
// Constants, microcode encoding and program for the post-order tree walk.
// ----------------------------------------------------------------------------
package atpw_pkg;

   localparam int MAX_SLOTS  = 63;
   localparam int SLOT_W     = $clog2(MAX_SLOTS + 1);
   localparam int ADDR_W     = $clog2(MAX_SLOTS);
   localparam int NODE_W     = SLOT_W + 1;
   localparam int STACK_CAP  = 8;
   localparam int SP_W       = $clog2(STACK_CAP);
   localparam int HEIGHT_W   = 3;
   localparam int CHAR_W     = 8;
   localparam logic [CHAR_W-1:0] EMPTY_MARK = 8'd48;

   // sequencer steps
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_INIT     = 4'd1;
   localparam logic [STEP_W-1:0] STEP_RD_CUR   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_TST_CUR  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_RD_RIGHT = 4'd4;
   localparam logic [STEP_W-1:0] STEP_TST_RGT  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_VISIT    = 4'd6;
   localparam logic [STEP_W-1:0] STEP_EMPTY    = 4'd7;
   localparam logic [STEP_W-1:0] STEP_PASS_END = 4'd8;

   // node store read source
   localparam logic [1:0] RD_NONE  = 2'd0;
   localparam logic [1:0] RD_CUR   = 2'd1;
   localparam logic [1:0] RD_RIGHT = 2'd2;
   localparam logic [1:0] RD_TOP   = 2'd3;

   // datapath operations
   localparam logic [2:0] OP_WAIT       = 3'd0;
   localparam logic [2:0] OP_INIT       = 3'd1;
   localparam logic [2:0] OP_NOP        = 3'd2;
   localparam logic [2:0] OP_TEST_CUR   = 3'd3;
   localparam logic [2:0] OP_TEST_RIGHT = 3'd4;
   localparam logic [2:0] OP_VISIT      = 3'd5;
   localparam logic [2:0] OP_EMPTY      = 3'd6;
   localparam logic [2:0] OP_PASS_END   = 3'd7;

   // jump conditions
   localparam logic [2:0] COND_NEVER      = 3'd0;
   localparam logic [2:0] COND_ALWAYS     = 3'd1;
   localparam logic [2:0] COND_LAUNCH     = 3'd2;
   localparam logic [2:0] COND_PRESENT    = 3'd3;
   localparam logic [2:0] COND_DEPTH_ZERO = 3'd4;
   localparam logic [2:0] COND_RIGHT_TAKE = 3'd5;
   localparam logic [2:0] COND_LAST_POP   = 3'd6;
   localparam logic [2:0] COND_FINAL_PASS = 3'd7;

   typedef struct packed {
      logic [1:0]        rd_sel;
      logic [2:0]        op;
      logic [2:0]        cond;
      logic [STEP_W-1:0] jmp;
      logic [STEP_W-1:0] nxt;
   } ucode_type;

   typedef struct packed {
      logic launch;
      logic present;
      logic depth_zero;
      logic right_take;
      logic last_pop;
      logic final_pass;
   } flags_type;

   // Control store: one word per step.
   function automatic ucode_type ucode_fetch(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         STEP_IDLE:     w = '{RD_NONE,  OP_WAIT,       COND_LAUNCH,     STEP_INIT,
                              STEP_IDLE};
         STEP_INIT:     w = '{RD_NONE,  OP_INIT,       COND_NEVER,      STEP_IDLE,
                              STEP_RD_CUR};
         STEP_RD_CUR:   w = '{RD_CUR,   OP_NOP,        COND_NEVER,      STEP_IDLE,
                              STEP_TST_CUR};
         STEP_TST_CUR:  w = '{RD_NONE,  OP_TEST_CUR,   COND_PRESENT,    STEP_RD_CUR,
                              STEP_RD_RIGHT};
         STEP_RD_RIGHT: w = '{RD_RIGHT, OP_NOP,        COND_DEPTH_ZERO, STEP_EMPTY,
                              STEP_TST_RGT};
         STEP_TST_RGT:  w = '{RD_TOP,   OP_TEST_RIGHT, COND_RIGHT_TAKE, STEP_RD_CUR,
                              STEP_VISIT};
         STEP_VISIT:    w = '{RD_NONE,  OP_VISIT,      COND_LAST_POP,   STEP_PASS_END,
                              STEP_RD_RIGHT};
         STEP_EMPTY:    w = '{RD_NONE,  OP_EMPTY,      COND_ALWAYS,     STEP_IDLE,
                              STEP_IDLE};
         STEP_PASS_END: w = '{RD_NONE,  OP_PASS_END,   COND_FINAL_PASS, STEP_IDLE,
                              STEP_INIT};
         default:       w = '{RD_NONE,  OP_WAIT,       COND_NEVER,      STEP_IDLE,
                              STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ hw/rtl/atpw_seq.sv @@
// ----------------------------------------------------------------------------
// atpw_seq
// Step counter and control store; picks the next step from the jump condition.
// ----------------------------------------------------------------------------
module atpw_seq
   import atpw_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ucode_type ctrl,
   output logic      busy
);

   logic [STEP_W-1:0] upc_ff;
   logic [STEP_W-1:0] upc_in;
   logic              take;

   assign ctrl = ucode_fetch(upc_ff);
   assign busy = (upc_ff != STEP_IDLE);

   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:      take = 1'b0;
         COND_ALWAYS:     take = 1'b1;
         COND_LAUNCH:     take = flags.launch;
         COND_PRESENT:    take = flags.present;
         COND_DEPTH_ZERO: take = flags.depth_zero;
         COND_RIGHT_TAKE: take = flags.right_take;
         COND_LAST_POP:   take = flags.last_pop;
         COND_FINAL_PASS: take = flags.final_pass;
      endcase
      upc_in = take ? ctrl.jmp : ctrl.nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

@@ hw/rtl/atpw_dpath.sv @@
// ----------------------------------------------------------------------------
// atpw_dpath
// Node store, index stack, walk registers and result register.
// ----------------------------------------------------------------------------
module atpw_dpath
   import atpw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ucode_type           ctrl,
   input  logic                accept,
   input  logic [CHAR_W-1:0]   node_char,
   input  logic                last_node,
   output flags_type           flags,
   output logic                rsp_valid,
   output logic [CHAR_W-1:0]   rsp_visit_char,
   output logic [HEIGHT_W-1:0] rsp_tree_height,
   output logic                rsp_empty_tree,
   output logic                rsp_last_visit
);

   logic [CHAR_W-1:0]   mem [0:MAX_SLOTS-1];
   logic [CHAR_W-1:0]   rdata_ff;
   logic                rd_ok_ff;
   logic [SLOT_W-1:0]   stack_ff [0:STACK_CAP-1];

   logic [SLOT_W-1:0]   slot_count_ff, slot_count_in;
   logic [NODE_W-1:0]   cur_ff, cur_in;
   logic [SLOT_W-1:0]   prev_ff, prev_in;
   logic [SP_W-1:0]     depth_ff, depth_in;
   logic [HEIGHT_W-1:0] maxd_ff, maxd_in;
   logic                pass_ff, pass_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [HEIGHT_W-1:0] rsp_height_ff, rsp_height_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [SLOT_W-1:0]   top;
   logic [NODE_W-1:0]   right;
   logic [NODE_W-1:0]   rd_node;
   logic                rd_en;
   logic                in_range;
   logic [ADDR_W-1:0]   rd_addr;
   logic                present;
   logic                store_room;
   logic [SP_W-1:0]     depth_up;

   assign top        = stack_ff[depth_ff - SP_W'(1)];
   assign right      = {top, 1'b1};
   assign present    = rd_ok_ff && (rdata_ff != EMPTY_MARK);
   assign store_room = (slot_count_ff < SLOT_W'(MAX_SLOTS));
   assign depth_up   = depth_ff + SP_W'(1);

   always_comb begin
      unique case (ctrl.rd_sel)
         RD_NONE:  rd_node = cur_ff;
         RD_CUR:   rd_node = cur_ff;
         RD_RIGHT: rd_node = right;
         RD_TOP:   rd_node = {1'b0, top};
      endcase
   end

   assign rd_en    = (ctrl.rd_sel != RD_NONE);
   assign in_range = (rd_node != '0) && (rd_node <= {1'b0, slot_count_ff});
   assign rd_addr  = ADDR_W'(rd_node - NODE_W'(1));

   assign flags.launch     = accept && last_node;
   assign flags.present    = present;
   assign flags.depth_zero = (depth_ff == '0);
   assign flags.right_take = present && ({1'b0, prev_ff} != right);
   assign flags.last_pop   = (depth_ff == SP_W'(1));
   assign flags.final_pass = pass_ff;

   // node store: one write port for loads, one registered read port for the walk
   always_ff @(posedge clock) begin
      if (accept && store_room) begin
         mem[slot_count_ff[ADDR_W-1:0]] <= node_char;
      end
      if (rd_en && in_range) begin
         rdata_ff <= mem[rd_addr];
      end
      if (rd_en) begin
         rd_ok_ff <= in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == OP_TEST_CUR && present) begin
         stack_ff[depth_ff] <= cur_ff[SLOT_W-1:0];
      end
   end

   always_comb begin
      slot_count_in = slot_count_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      depth_in      = depth_ff;
      maxd_in       = maxd_ff;
      pass_in       = pass_ff;
      rsp_valid_in  = 1'b0;
      rsp_char_in   = rsp_char_ff;
      rsp_height_in = rsp_height_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (ctrl.op)
         OP_WAIT: begin
            if (accept && store_room) begin
               slot_count_in = slot_count_ff + SLOT_W'(1);
            end
            if (accept && last_node) begin
               pass_in = 1'b0;
               maxd_in = '0;
            end
         end
         OP_INIT: begin
            cur_in   = NODE_W'(1);
            prev_in  = '0;
            depth_in = '0;
         end
         OP_NOP: begin
         end
         OP_TEST_CUR: begin
            if (present) begin
               depth_in = depth_up;
               cur_in   = {cur_ff[NODE_W-2:0], 1'b0};
               if (!pass_ff && HEIGHT_W'(depth_up) > maxd_ff) begin
                  maxd_in = HEIGHT_W'(depth_up);
               end
            end
         end
         OP_TEST_RIGHT: begin
            if (flags.right_take) begin
               cur_in = right;
            end
         end
         OP_VISIT: begin
            prev_in  = top;
            depth_in = depth_ff - SP_W'(1);
            if (pass_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = rdata_ff;
               rsp_height_in = maxd_ff;
               rsp_empty_in  = 1'b0;
               rsp_last_in   = flags.last_pop;
            end
         end
         OP_EMPTY: begin
            slot_count_in = '0;
            rsp_valid_in  = 1'b1;
            rsp_char_in   = '0;
            rsp_height_in = '0;
            rsp_empty_in  = 1'b1;
            rsp_last_in   = 1'b1;
         end
         OP_PASS_END: begin
            if (pass_ff) begin
               slot_count_in = '0;
            end else begin
               pass_in = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= '0;
         depth_ff      <= '0;
         pass_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_count_ff <= slot_count_in;
         depth_ff      <= depth_in;
         pass_ff       <= pass_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      maxd_ff       <= maxd_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_height_ff <= rsp_height_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_visit_char  = rsp_char_ff;
   assign rsp_tree_height = rsp_height_ff;
   assign rsp_empty_tree  = rsp_empty_ff;
   assign rsp_last_visit  = rsp_last_ff;

endmodule

@@ hw/rtl/array_tree_postorder_walk.sv @@
// ----------------------------------------------------------------------------
// array_tree_postorder_walk
// Post-order walk of a binary tree loaded in level order, one slot per transfer.
// ----------------------------------------------------------------------------
// Load the tree one slot per transfer (start high while busy is low): slot k
// is node k+1, node i has children 2i and 2i+1, and the character '0' marks
// an empty slot. Up to 63 slots are kept; further slots are dropped, though
// their last_node bit still counts. Busy stays low between loads. The
// transfer with last_node set raises busy and starts the walk, which a
// microcoded sequencer runs over a node store with one write port and a
// registered read port: two passes over the tree, the first to find the
// depth of the deepest reachable node and the second to emit. Every
// reachable node comes out once, in post order, as a one-cycle strobe on
// rsp_valid with the tree height alongside; the root is last and carries
// rsp_last_visit. An empty root gives a single result with rsp_empty_tree
// set. Results cannot be held off: take each one in its cycle. When busy
// falls the store is empty and ready for the next tree.
// ----------------------------------------------------------------------------
module array_tree_postorder_walk
   import atpw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CHAR_W-1:0]   req_node_char,
   input  logic                req_last_node,
   output logic                rsp_valid,
   output logic [CHAR_W-1:0]   rsp_visit_char,
   output logic [HEIGHT_W-1:0] rsp_tree_height,
   output logic                rsp_empty_tree,
   output logic                rsp_last_visit
);

   ucode_type ctrl;
   flags_type flags;
   logic      req_accept;

   // a load transfer completes only while the sequencer rests in its idle step
   assign req_accept = start && !busy;

   // control store and step counter
   atpw_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   // store, stack and result register, driven by the current control word
   atpw_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .accept          (req_accept),
      .node_char       (req_node_char),
      .last_node       (req_last_node),
      .flags           (flags),
      .rsp_valid       (rsp_valid),
      .rsp_visit_char  (rsp_visit_char),
      .rsp_tree_height (rsp_tree_height),
      .rsp_empty_tree  (rsp_empty_tree),
      .rsp_last_visit  (rsp_last_visit)
   );

endmodule

@@ hw/rtl/atpw_checker.sv @@
// ----------------------------------------------------------------------------
// atpw_checker
// Port-level checks on the tree walk block, bound to the top level.
// ----------------------------------------------------------------------------
`include "array_tree_postorder_walk_assert.svh"

module atpw_checker
   import atpw_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                req_last_node,
   input logic                rsp_valid,
   input logic [CHAR_W-1:0]   rsp_visit_char,
   input logic [HEIGHT_W-1:0] rsp_tree_height,
   input logic                rsp_empty_tree,
   input logic                rsp_last_visit
);

   logic load_last;
   logic load_more;
   logic empty_visit;
   logic empty_shape;
   logic tree_visit;
   logic last_strobe;

   assign load_last   = start && !busy && req_last_node;
   assign load_more   = start && !busy && !req_last_node;
   assign empty_visit = rsp_valid && rsp_empty_tree;
   assign empty_shape = rsp_last_visit && (rsp_visit_char == '0) && (rsp_tree_height == '0);
   assign tree_visit  = rsp_valid && !rsp_empty_tree;
   assign last_strobe = rsp_valid && rsp_last_visit;

   `ATPW_ASSERT_NEXT(a_walk_starts, clock, reset, load_last, busy, "walk did not start")
   `ATPW_ASSERT_NEXT(a_load_stays_idle, clock, reset, load_more, !busy, "busy after plain load")
   `ATPW_ASSERT_NOW(a_empty_result, clock, reset, empty_visit, empty_shape, "bad empty result")
   `ATPW_ASSERT_NOW(a_height_set, clock, reset, tree_visit, rsp_tree_height != '0, "zero height")
   `ATPW_ASSERT_NEXT(a_last_ends, clock, reset, last_strobe, !rsp_valid, "result after last")

endmodule

bind array_tree_postorder_walk atpw_checker u_atpw_checker (.*);
